@@ hdl/nfta_pkg.sv @@
package nfta_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORD_LSB  = 5;
  localparam int unsigned LIM_W     = 6;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned MD_W      = 10;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned OWN_W     = 16;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OP_W      = 2;

  localparam logic [CFG_W-1:0] DEPTH_LIM_RST = 9'd256;
  localparam logic [POS_W-1:0] FIRST_TAG     = 9'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FIND  = 2'd2,
    OP_NONE  = 2'd3
  } nfta_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_TAG   = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOT_BUSY = 3'd3,
    ST_MISMATCH = 3'd4
  } nfta_status_e;

  // One word of the busy map and the window of bit positions to search in it.
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [WORD_LSB-1:0] lo;
    logic [LIM_W-1:0]    lim;
  } nfta_scan_req_t;

  typedef struct packed {
    logic                hit;
    logic [WORD_LSB-1:0] idx;
  } nfta_scan_res_t;

endpackage

@@ hdl/nfta_cmd_if.sv @@
interface nfta_cmd_if;
  import nfta_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [TAG_W-1:0] tag;
  logic [OWN_W-1:0] owner_id;

  modport source (output valid, output op, output tag, output owner_id, input ready);
  modport sink (input valid, input op, input tag, input owner_id, output ready);
endinterface

@@ hdl/nfta_rsp_if.sv @@
interface nfta_rsp_if;
  import nfta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    tag_out;
  logic [OWN_W-1:0]    owner_out;

  modport source (output valid, output status, output tag_out, output owner_out,
                  input ready);
  modport sink (input valid, input status, input tag_out, input owner_out,
                output ready);
endinterface

@@ hdl/nfta_scan.sv @@
module nfta_scan
  import nfta_pkg::*;
(
  input  nfta_scan_req_t req_i,
  output nfta_scan_res_t res_o
);

  logic [WORD_W-1:0] cand;

  // A bit is a candidate when it is free, at or above the start bit and below the limit.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !req_i.word[b] && (WORD_LSB'(b) >= req_i.lo) && (LIM_W'(b) < req_i.lim);
    end
  end

  always_comb begin
    res_o.hit = |cand;
    res_o.idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res_o.idx = WORD_LSB'(b);
      end
    end
  end

endmodule

@@ hdl/nfta_owner_ram.sv @@
module nfta_owner_ram #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned WIDTH   = 16,
  parameter int unsigned AW      = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/next_fit_tag_allocator_core.sv @@
// Channel  Dir  Handshake       Payload
// cmd_i    in   valid / ready   op, tag, owner_id
// rsp_o    out  valid / ready   status, tag_out, owner_out
// cfg      in   cfg_we_i        cfg_wdata_i (depth limit)
//
// Allocate visits the 32-bit busy-map words in the scan unit one per cycle, up to
// 2 * ceil(depth / 32) words with the retry from 1, and then replies.
// Free and find pass S_CHECK before S_REPLY; the unused op and a range error skip it.
// Reset clears the busy map at once and sets the next pointer to 1.
// A stalled result sits in the output register; the next command is taken meanwhile.
module next_fit_tag_allocator_core
  import nfta_pkg::*;
#(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned OWNER_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  nfta_cmd_if.sink         cmd_i,
  nfta_rsp_if.source       rsp_o
);

  // Tags never reach 512 because the depth register has nine bits.
  localparam int unsigned USED   = (DEPTH > 512) ? 512 : DEPTH;
  localparam int unsigned NWORDS = (USED + WORD_W - 1) / WORD_W;
  localparam int unsigned WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned NW2    = 1 << WI_W;
  localparam int unsigned AW     = $clog2(USED);
  localparam logic [MD_W-1:0] DEPTH_CAP = MD_W'(USED);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_REPLY
  } state_e;

  state_e                state_q;
  logic [CFG_W-1:0]      depth_lim_q;
  logic [WORD_W-1:0]     busy_q [NW2];
  logic [POS_W-1:0]      np_q;
  logic [POS_W-1:0]      pos_q;
  logic                  retry_q;
  logic [MD_W-1:0]       md_q;
  nfta_op_e              op_q;
  logic [TAG_W-1:0]      tag_q;
  logic [OWNER_BITS-1:0] own_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [TAG_W-1:0]      res_tag_q;
  logic [OWN_W-1:0]      res_owner_q;
  logic                  rsp_valid_q;
  logic [STATUS_W-1:0]   rsp_status_q;
  logic [TAG_W-1:0]      rsp_tag_q;
  logic [OWN_W-1:0]      rsp_owner_q;

  logic [MD_W-1:0]       md_now;
  logic                  cmd_fire;
  logic                  cmd_in_range;
  logic [WI_W-1:0]       scan_wi;
  logic [MD_W-1:0]       scan_base;
  logic [MD_W-1:0]       scan_next;
  logic [MD_W-1:0]       scan_rem;
  logic [POS_W-1:0]      found_pos;
  logic [MD_W-1:0]       md_last;
  nfta_scan_req_t        scan_req;
  nfta_scan_res_t        scan_res;
  logic [WI_W-1:0]       chk_wi;
  logic                  chk_busy;
  logic [OWNER_BITS-1:0] ram_rdata;
  logic                  ram_we;
  logic                  out_free;

  assign md_now = ({1'b0, depth_lim_q} > DEPTH_CAP) ? DEPTH_CAP : {1'b0, depth_lim_q};

  assign cmd_i.ready  = (state_q == S_IDLE);
  assign cmd_fire     = cmd_i.valid && cmd_i.ready;
  assign cmd_in_range = (cmd_i.tag != '0) && ({2'b00, cmd_i.tag} < md_now);

  // Scan window for the word that holds pos_q, clipped at the depth in use.
  assign scan_wi   = WI_W'(pos_q >> WORD_LSB);
  assign scan_base = {1'b0, pos_q[POS_W-1:WORD_LSB], {WORD_LSB{1'b0}}};
  assign scan_next = scan_base + MD_W'(WORD_W);
  assign scan_rem  = md_q - scan_base;
  assign md_last   = md_q - MD_W'(1);

  always_comb begin
    scan_req.word = busy_q[scan_wi];
    scan_req.lo   = pos_q[WORD_LSB-1:0];
    if (md_q <= scan_base) begin
      scan_req.lim = '0;
    end else if (scan_rem >= MD_W'(WORD_W)) begin
      scan_req.lim = LIM_W'(WORD_W);
    end else begin
      scan_req.lim = scan_rem[LIM_W-1:0];
    end
  end

  nfta_scan u_scan (
    .req_i (scan_req),
    .res_o (scan_res)
  );

  assign found_pos = {pos_q[POS_W-1:WORD_LSB], scan_res.idx};
  assign ram_we    = (state_q == S_SCAN) && scan_res.hit;

  nfta_owner_ram #(
    .ENTRIES (USED),
    .WIDTH   (OWNER_BITS),
    .AW      (AW)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(found_pos)),
    .wdata_i (own_q),
    .re_i    (cmd_fire),
    .raddr_i (AW'(cmd_i.tag)),
    .rdata_o (ram_rdata)
  );

  assign chk_wi   = WI_W'(tag_q >> WORD_LSB);
  assign chk_busy = busy_q[chk_wi][tag_q[WORD_LSB-1:0]];
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      depth_lim_q  <= DEPTH_LIM_RST;
      for (int w = 0; w < NW2; w++) begin
        busy_q[w] <= '0;
      end
      np_q         <= FIRST_TAG;
      pos_q        <= '0;
      retry_q      <= 1'b0;
      md_q         <= '0;
      op_q         <= OP_NONE;
      tag_q        <= '0;
      own_q        <= '0;
      res_status_q <= '0;
      res_tag_q    <= '0;
      res_owner_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_tag_q    <= '0;
      rsp_owner_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        depth_lim_q <= cfg_wdata_i;
      end
      // In S_REPLY the output register is reloaded instead of drained.
      if (rsp_valid_q && rsp_o.ready && (state_q != S_REPLY)) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (cmd_fire) begin
            op_q         <= nfta_op_e'(cmd_i.op);
            tag_q        <= cmd_i.tag;
            own_q        <= OWNER_BITS'(cmd_i.owner_id);
            md_q         <= md_now;
            pos_q        <= np_q;
            retry_q      <= (np_q > FIRST_TAG);
            res_tag_q    <= '0;
            res_owner_q  <= '0;
            case (nfta_op_e'(cmd_i.op))
              OP_ALLOC: begin
                res_status_q <= ST_OK;
                state_q      <= S_SCAN;
              end
              OP_FREE, OP_FIND: begin
                if (cmd_in_range) begin
                  res_status_q <= ST_OK;
                  state_q      <= S_CHECK;
                end else begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_REPLY;
                end
              end
              default: begin
                res_status_q <= ST_OK;
                state_q      <= S_REPLY;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (scan_res.hit) begin
            busy_q[scan_wi][scan_res.idx] <= 1'b1;
            np_q      <= ({1'b0, found_pos} < md_last) ? found_pos + POS_W'(1) : FIRST_TAG;
            res_tag_q <= TAG_W'(found_pos);
            state_q   <= S_REPLY;
          end else if (scan_next >= md_q) begin
            // End of a pass: wrap around to tag 1 once, if the pass did not start there.
            if (retry_q) begin
              retry_q <= 1'b0;
              pos_q   <= FIRST_TAG;
            end else begin
              res_status_q <= ST_NO_TAG;
              state_q      <= S_REPLY;
            end
          end else begin
            pos_q <= scan_next[POS_W-1:0];
          end
        end

        S_CHECK: begin
          if (!chk_busy) begin
            res_status_q <= ST_NOT_BUSY;
          end else if (op_q == OP_FREE) begin
            if (ram_rdata != own_q) begin
              res_status_q <= ST_MISMATCH;
            end else begin
              busy_q[chk_wi][tag_q[WORD_LSB-1:0]] <= 1'b0;
            end
          end else begin
            res_owner_q <= OWN_W'(ram_rdata);
          end
          state_q <= S_REPLY;
        end

        S_REPLY: begin
          if (out_free) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status_q;
            rsp_tag_q    <= res_tag_q;
            rsp_owner_q  <= res_owner_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.tag_out   = rsp_tag_q;
  assign rsp_o.owner_out = rsp_owner_q;

endmodule

@@ hdl/nfta_checker.sv @@
module nfta_checker
  import nfta_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cmd_valid,
  input logic                cmd_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [TAG_W-1:0]    rsp_tag,
  input logic [OWN_W-1:0]    rsp_owner
);

  // Every command keeps the block busy for at least the following cycle.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while the previous item is still in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tag)
      && $stable(rsp_owner))
    else $error("stalled result changed");

  // A failed item carries no tag and no owner.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_tag == '0) && (rsp_owner == '0))
    else $error("error result with nonzero payload");

  // An allocated tag and a found owner never come in the same item.
  a_tag_or_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_tag != '0) |-> (rsp_owner == '0))
    else $error("result carries both a tag and an owner");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NO_TAG)
      || (rsp_status == ST_RANGE) || (rsp_status == ST_NOT_BUSY)
      || (rsp_status == ST_MISMATCH))
    else $error("unknown status code");

endmodule

bind next_fit_tag_allocator_core nfta_checker u_nfta_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cmd_valid  (cmd_i.valid),
  .cmd_ready  (cmd_i.ready),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_status (rsp_o.status),
  .rsp_tag    (rsp_o.tag_out),
  .rsp_owner  (rsp_o.owner_out)
);

@@ verif/next_fit_tag_allocator_core_tb.sv @@
module next_fit_tag_allocator_core_tb;
  import nfta_pkg::*;

  localparam int unsigned TAGS = 256;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [OWN_W-1:0]    owner;
  } reply_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  nfta_cmd_if cmd_bus ();
  nfta_rsp_if rsp_bus ();

  next_fit_tag_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_bus),
    .rsp_o       (rsp_bus)
  );

  // Shadow of the allocator: busy bits, owners, scan start and depth register.
  logic             tag_busy  [TAGS];
  logic [OWN_W-1:0] tag_owner [TAGS];
  int unsigned      scan_from;
  logic [CFG_W-1:0] depth_cfg;

  reply_t      replies_due [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned replies_checked;
  int unsigned status_count [5];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned depth_in_use();
    return (depth_cfg > TAGS) ? TAGS : depth_cfg;
  endfunction

  function automatic bit tag_in_range(int unsigned t, int unsigned md);
    return (t >= FIRST_TAG) && (t < md);
  endfunction

  // First free tag in [from, md), or md when every one is busy.
  function automatic int unsigned first_free(int unsigned from, int unsigned md);
    for (int unsigned t = from; t < md; t++) begin
      if (!tag_busy[t]) return t;
    end
    return md;
  endfunction

  function automatic reply_t predict_reply(input logic [OP_W-1:0] op,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [OWN_W-1:0] own);
    reply_t      r;
    int unsigned md;
    int unsigned t;
    r  = '0;
    md = depth_in_use();
    case (op)
      OP_ALLOC: begin
        t = first_free(scan_from, md);
        if (!tag_in_range(t, md) && scan_from > FIRST_TAG) t = first_free(FIRST_TAG, md);
        if (!tag_in_range(t, md)) begin
          r.status = ST_NO_TAG;
        end else begin
          scan_from    = (t < md - 1) ? t + 1 : FIRST_TAG;
          tag_busy[t]  = 1'b1;
          tag_owner[t] = own;
          r.tag        = t[TAG_W-1:0];
        end
      end
      OP_FREE: begin
        if (!tag_in_range(tag, md)) r.status = ST_RANGE;
        else if (!tag_busy[tag]) r.status = ST_NOT_BUSY;
        else if (tag_owner[tag] != own) r.status = ST_MISMATCH;
        else tag_busy[tag] = 1'b0;
      end
      OP_FIND: begin
        if (!tag_in_range(tag, md)) r.status = ST_RANGE;
        else if (!tag_busy[tag]) r.status = ST_NOT_BUSY;
        else r.owner = tag_owner[tag];
      end
      default: ;  // The unused op answers all zeros and changes nothing.
    endcase
    return r;
  endfunction

  // Results are checked before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin : check_and_predict
    reply_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result status %0d tag %0d owner %h", $time,
                   rsp_bus.status, rsp_bus.tag_out, rsp_bus.owner_out);
          errors++;
        end else begin
          want = replies_due.pop_front();
          replies_checked++;
          status_count[want.status]++;
          if (rsp_bus.status !== want.status || rsp_bus.tag_out !== want.tag ||
              rsp_bus.owner_out !== want.owner) begin
            $display("%0t: expected status %0d tag %0d owner %h, got status %0d tag %0d owner %h",
                     $time, want.status, want.tag, want.owner,
                     rsp_bus.status, rsp_bus.tag_out, rsp_bus.owner_out);
            errors++;
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready)
        replies_due.push_back(predict_reply(cmd_bus.op, cmd_bus.tag, cmd_bus.owner_id));
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Leaves the caller at a falling edge after the sender's random gap.
  task automatic pace_sender();
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  task automatic drive_cmd(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                           input logic [OWN_W-1:0] own);
    cmd_bus.valid    <= 1'b1;
    cmd_bus.op       <= op;
    cmd_bus.tag      <= tag;
    cmd_bus.owner_id <= own;
    do @(posedge clk_i); while (!cmd_bus.ready);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                          input logic [OWN_W-1:0] own);
    pace_sender();
    drive_cmd(op, tag, own);
  endtask

  task automatic wait_all_replies();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_depth(input logic [CFG_W-1:0] d);
    wait_all_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    depth_cfg = d;
  endtask

  function automatic int pick_held_tag(int unsigned md);
    int unsigned start;
    int unsigned t;
    start = $urandom_range(TAGS - 1);
    for (int unsigned i = 0; i < TAGS; i++) begin
      t = (start + i) % TAGS;
      if (tag_in_range(t, md) && tag_busy[t]) return t;
    end
    return -1;
  endfunction

  // Mostly allocate and release of held tags with the right owner; the rest is noise.
  task automatic send_random_cmd();
    int unsigned      pick;
    int               held;
    logic [OP_W-1:0]  op;
    logic [TAG_W-1:0] tag;
    logic [OWN_W-1:0] own;
    pace_sender();
    held = pick_held_tag(depth_in_use());
    pick = $urandom_range(99);
    op   = OP_ALLOC;
    tag  = TAG_W'($urandom_range(255));
    own  = OWN_W'($urandom_range(16'hFFFF));
    if (pick < 4) own = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    if (held >= 0 && pick >= 40 && pick < 88) begin
      tag = TAG_W'(held);
      if (pick < 72) begin
        op  = OP_FREE;
        own = tag_owner[held];
      end else if (pick < 82) begin
        op = OP_FIND;
      end else begin
        op  = OP_FREE;
        own = tag_owner[held] ^ 16'($urandom_range(16'hFFFF, 1));
      end
    end else if (pick >= 88 && pick < 94) begin
      op = ($urandom_range(1) != 0) ? OP_FREE : OP_FIND;
    end else if (pick >= 94) begin
      op = OP_NONE;
    end
    drive_cmd(op, tag, own);
  endtask

  task automatic test_directed_cases();
    send_cmd(OP_FIND, 8'd0, 16'h0000);
    send_cmd(OP_FREE, 8'd0, 16'h0000);
    send_cmd(OP_FIND, 8'd255, 16'hFFFF);
    send_cmd(OP_FREE, 8'd200, 16'hFFFF);
    // Owner zero is a legal handle like any other.
    send_cmd(OP_ALLOC, 8'd0, 16'h0000);
    send_cmd(OP_ALLOC, 8'hFF, 16'hFFFF);
    send_cmd(OP_FIND, 8'd1, 16'h0000);
    send_cmd(OP_FIND, 8'd2, 16'h0000);
    send_cmd(OP_FREE, 8'd1, 16'h5A5A);
    send_cmd(OP_FREE, 8'd1, 16'h0000);
    send_cmd(OP_FREE, 8'd1, 16'h0000);
    send_cmd(OP_NONE, 8'hFF, 16'hFFFF);
    send_cmd(OP_ALLOC, 8'd0, 16'h1234);
    // With a depth of zero or one no tag is valid.
    set_depth(9'd0);
    send_cmd(OP_ALLOC, 8'd0, 16'h0001);
    send_cmd(OP_FREE, 8'd1, 16'h0000);
    send_cmd(OP_FIND, 8'd0, 16'h0000);
    set_depth(9'd1);
    send_cmd(OP_ALLOC, 8'd0, 16'h0002);
    send_cmd(OP_FIND, 8'd1, 16'h0000);
    // A depth beyond the table acts as the full table.
    set_depth(9'h1FF);
    send_cmd(OP_FIND, 8'd255, 16'h0000);
    send_cmd(OP_ALLOC, 8'd0, 16'hA5A5);
    // Shrinking leaves the scan start past the depth, so only the retry can succeed.
    set_depth(9'd4);
    send_cmd(OP_ALLOC, 8'd0, 16'h00FF);
    send_cmd(OP_ALLOC, 8'd0, 16'hFF00);
    send_cmd(OP_FIND, 8'd3, 16'h0000);
    send_cmd(OP_FREE, 8'd3, 16'h1234);
    send_cmd(OP_FIND, 8'd255, 16'h0000);
  endtask

  task automatic test_exhaust_and_wrap();
    int               held_tag [$];
    logic [OWN_W-1:0] held_own [$];
    set_depth(DEPTH_LIM_RST);
    for (int t = 1; t < TAGS; t++) begin
      if (tag_busy[t]) begin
        held_tag.push_back(t);
        held_own.push_back(tag_owner[t]);
      end
    end
    foreach (held_tag[i]) send_cmd(OP_FREE, TAG_W'(held_tag[i]), held_own[i]);
    // Fill every tag, including the top one, then run one allocate into a full map.
    for (int i = 0; i < TAGS; i++) send_cmd(OP_ALLOC, 8'd0, OWN_W'($urandom_range(16'hFFFF)));
    wait_all_replies();
    send_cmd(OP_FIND, 8'd255, 16'h0000);
    send_cmd(OP_FREE, 8'd255, tag_owner[255]);
    send_cmd(OP_FREE, 8'd7, tag_owner[7]);
    send_cmd(OP_ALLOC, 8'd0, 16'h7777);
    send_cmd(OP_ALLOC, 8'd0, 16'h8888);
    send_cmd(OP_ALLOC, 8'd0, 16'h9999);
  endtask

  task automatic test_backpressure();
    set_depth(9'd40);
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_left = 400;
    for (int i = 0; i < 80; i++) send_random_cmd();
    wait_all_replies();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] depth_plan [12];
    depth_plan = '{9'd256, 9'd17, 9'h1FF, 9'd2, 9'd64, 9'd255,
                   9'd0, 9'd200, 9'd300, 9'd33, 9'd128, 9'd3};
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        if (phase == 3 && seg == 1) set_depth(CFG_W'($urandom_range(511)));
        else set_depth(depth_plan[phase * 3 + seg]);
        for (int i = 0; i < 90; i++) send_random_cmd();
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = DEPTH_LIM_RST;
    cmd_bus.valid    = 1'b0;
    cmd_bus.op       = OP_NONE;
    cmd_bus.tag      = '0;
    cmd_bus.owner_id = '0;
    rsp_bus.ready    = 1'b0;
    errors           = 0;
    items_sent       = 0;
    replies_checked  = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_left        = 0;
    scan_from        = FIRST_TAG;
    depth_cfg        = DEPTH_LIM_RST;
    foreach (status_count[i]) status_count[i] = 0;
    foreach (tag_busy[i]) begin
      tag_busy[i]  = 1'b0;
      tag_owner[i] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_exhaust_and_wrap();
    test_backpressure();
    test_random_traffic();

    stall_pct = 0;
    wait_all_replies();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results at depths 0 to 511 under four idle mixes.",
             items_sent, replies_checked);
    $display("Results: %0d ok, %0d no free tag, %0d out of range, %0d not busy, %0d wrong owner.",
             status_count[ST_OK], status_count[ST_NO_TAG], status_count[ST_RANGE],
             status_count[ST_NOT_BUSY], status_count[ST_MISMATCH]);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("next_fit_tag_allocator_core_tb: done, clean");
    end else begin
      $display("next_fit_tag_allocator_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results still outstanding.", replies_due.size());
    $display("next_fit_tag_allocator_core_tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/nfta_pkg.sv
hdl/nfta_cmd_if.sv
hdl/nfta_rsp_if.sv
hdl/nfta_scan.sv
hdl/nfta_owner_ram.sv
hdl/next_fit_tag_allocator_core.sv
hdl/nfta_checker.sv
verif/next_fit_tag_allocator_core_tb.sv
